FILE: rtl/core/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, held off during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/core/i2car_pkg.sv
`timescale 1ns / 1ps
package i2car_pkg;

  localparam logic [7:0] DELAY_RESET = 8'd30;
  localparam logic [6:0] ADDR_RESET  = 7'd72;

  // configuration register indexes
  localparam logic CFG_DELAY_TICKS    = 1'b0;
  localparam logic CFG_DEVICE_ADDRESS = 1'b1;

  typedef enum logic [4:0] {
    PH_IDLE   = 5'd0,
    PH_S1A    = 5'd1,
    PH_S1B    = 5'd2,
    PH_TXA_LO = 5'd3,
    PH_TXA_HI = 5'd4,
    PH_AKA_LO = 5'd5,
    PH_AKA_HI = 5'd6,
    PH_NSA    = 5'd7,
    PH_TXC_LO = 5'd8,
    PH_TXC_HI = 5'd9,
    PH_AKC_LO = 5'd10,
    PH_AKC_HI = 5'd11,
    PH_NSC    = 5'd12,
    PH_P1     = 5'd13,
    PH_S2A    = 5'd14,
    PH_S2B    = 5'd15,
    PH_TXR_LO = 5'd16,
    PH_TXR_HI = 5'd17,
    PH_AKR_LO = 5'd18,
    PH_AKR_HI = 5'd19,
    PH_NSR    = 5'd20,
    PH_RX_HI  = 5'd21,
    PH_RX_LO  = 5'd22,
    PH_P2     = 5'd23
  } phase_t;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       busy;
    logic       done;
    logic       ack_error;
    logic [7:0] raw;
    logic [8:0] scaled;
  } res_t;

endpackage

FILE: rtl/core/i2car_seq.sv
`timescale 1ns / 1ps
module i2car_seq (
  input  logic              clk,
  input  logic              rst,
  input  logic              tick,
  input  logic              start_read,
  input  logic [7:0]        control_byte,
  input  logic              sda_in,
  input  logic [7:0]        delay_ticks,
  input  logic [6:0]        device_address,
  output i2car_pkg::res_t   res
);
  import i2car_pkg::*;

  phase_t     phase, phase_next, enter_phase;
  logic [3:0] bit_count, bit_next;
  logic [7:0] shift_byte, shift_next;
  logic [7:0] wait_count, wait_next;
  logic       nack_seen, nack_next;
  logic [7:0] held_control, held_next;
  logic       scl_level, sda_level;
  logic       lvl_scl, lvl_sda;
  logic       do_enter;
  logic       done;
  logic [3:0] bit_inc;
  logic [7:0] addr2;

  // raw * 500 / 255: reciprocal estimate is low by at most one, fixed by one compare
  function automatic logic [8:0] scale_raw(input logic [7:0] raw);
    logic [16:0] p;
    logic [31:0] prod;
    logic [8:0]  q0;
    logic [17:0] r;
    p    = 17'(raw) * 17'd500;
    prod = 32'(raw) * 32'd16448000;
    q0   = prod[31:23];
    r    = 18'(p) + 18'(q0) - {1'b0, q0, 8'b0};
    return (r >= 18'd255) ? 9'(q0 + 9'd1) : q0;
  endfunction

  assign bit_inc = 4'(bit_count + 4'd1);
  assign addr2   = {device_address, 1'b0};

  // next state
  always_comb begin
    phase_next  = phase;
    bit_next    = bit_count;
    shift_next  = shift_byte;
    wait_next   = wait_count;
    nack_next   = nack_seen;
    held_next   = held_control;
    enter_phase = phase;
    do_enter    = 1'b0;
    done        = 1'b0;
    if (phase == PH_IDLE) begin
      if (start_read) begin
        held_next   = control_byte;
        nack_next   = 1'b0;
        shift_next  = 8'd0;
        bit_next    = 4'd0;
        enter_phase = PH_S1A;
        do_enter    = 1'b1;
      end
    end else if (wait_count > 8'd1) begin
      wait_next = wait_count - 8'd1;
    end else begin
      do_enter = 1'b1;
      unique case (phase)
        PH_S1A: enter_phase = PH_S1B;
        PH_S1B: begin
          shift_next  = addr2;
          bit_next    = 4'd0;
          enter_phase = PH_TXA_LO;
        end
        PH_S2A: enter_phase = PH_S2B;
        PH_S2B: begin
          shift_next  = addr2 | 8'h01;
          bit_next    = 4'd0;
          enter_phase = PH_TXR_LO;
        end
        PH_TXA_LO: enter_phase = PH_TXA_HI;
        PH_TXC_LO: enter_phase = PH_TXC_HI;
        PH_TXR_LO: enter_phase = PH_TXR_HI;
        PH_TXA_HI, PH_TXC_HI, PH_TXR_HI: begin
          shift_next = {shift_byte[6:0], 1'b0};
          bit_next   = bit_inc;
          if (bit_inc[3]) begin
            enter_phase = (phase == PH_TXA_HI) ? PH_AKA_LO :
                          (phase == PH_TXC_HI) ? PH_AKC_LO : PH_AKR_LO;
          end else begin
            enter_phase = (phase == PH_TXA_HI) ? PH_TXA_LO :
                          (phase == PH_TXC_HI) ? PH_TXC_LO : PH_TXR_LO;
          end
        end
        PH_AKA_LO: enter_phase = PH_AKA_HI;
        PH_AKC_LO: enter_phase = PH_AKC_HI;
        PH_AKR_LO: enter_phase = PH_AKR_HI;
        PH_AKA_HI, PH_NSA: begin
          if (phase == PH_AKA_HI && sda_in) begin
            nack_next   = 1'b1;
            enter_phase = PH_NSA;
          end else begin
            shift_next  = held_control;
            bit_next    = 4'd0;
            enter_phase = PH_TXC_LO;
          end
        end
        PH_AKC_HI, PH_NSC: begin
          if (phase == PH_AKC_HI && sda_in) begin
            nack_next   = 1'b1;
            enter_phase = PH_NSC;
          end else begin
            enter_phase = PH_P1;
          end
        end
        PH_AKR_HI, PH_NSR: begin
          if (phase == PH_AKR_HI && sda_in) begin
            nack_next   = 1'b1;
            enter_phase = PH_NSR;
          end else begin
            shift_next  = 8'd0;
            bit_next    = 4'd0;
            enter_phase = PH_RX_HI;
          end
        end
        PH_P1: enter_phase = PH_S2A;
        PH_RX_HI: begin
          shift_next  = {shift_byte[6:0], sda_in};
          enter_phase = PH_RX_LO;
        end
        PH_RX_LO: begin
          bit_next    = bit_inc;
          enter_phase = bit_inc[3] ? PH_P2 : PH_RX_HI;
        end
        PH_P2: begin
          done        = 1'b1;
          enter_phase = PH_IDLE;
        end
        default: enter_phase = PH_IDLE;
      endcase
    end
    if (do_enter) begin
      phase_next = enter_phase;
      wait_next  = (enter_phase == PH_IDLE) ? 8'd0 : delay_ticks;
    end
  end

  // pin levels of the phase being entered
  always_comb begin
    unique case (enter_phase)
      PH_S1A, PH_S2A, PH_AKA_HI, PH_AKC_HI, PH_AKR_HI, PH_RX_HI: begin
        lvl_scl = 1'b1;
        lvl_sda = 1'b1;
      end
      PH_S1B, PH_S2B, PH_NSA, PH_NSC, PH_NSR, PH_P1, PH_P2: begin
        lvl_scl = 1'b1;
        lvl_sda = 1'b0;
      end
      PH_TXA_LO, PH_TXC_LO, PH_TXR_LO: begin
        lvl_scl = 1'b0;
        lvl_sda = shift_next[7];
      end
      PH_TXA_HI, PH_TXC_HI, PH_TXR_HI: begin
        lvl_scl = 1'b1;
        lvl_sda = shift_next[7];
      end
      PH_AKA_LO, PH_AKC_LO, PH_AKR_LO, PH_RX_LO: begin
        lvl_scl = 1'b0;
        lvl_sda = 1'b1;
      end
      default: begin
        lvl_scl = 1'b1;
        lvl_sda = 1'b1;
      end
    endcase
  end

  // result of this tick: pins as they stood, status after the update
  always_comb begin
    res.scl       = scl_level;
    res.sda       = sda_level;
    res.busy      = (phase_next != PH_IDLE);
    res.done      = done;
    res.ack_error = nack_next;
    res.raw       = done ? shift_byte : 8'd0;
    res.scaled    = done ? scale_raw(shift_byte) : 9'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      bit_count    <= 4'd0;
      shift_byte   <= 8'd0;
      wait_count   <= 8'd0;
      nack_seen    <= 1'b0;
      held_control <= 8'd0;
      scl_level    <= 1'b1;
      sda_level    <= 1'b1;
    end else if (tick) begin
      phase        <= phase_next;
      bit_count    <= bit_next;
      shift_byte   <= shift_next;
      wait_count   <= wait_next;
      nack_seen    <= nack_next;
      held_control <= held_next;
      if (do_enter) begin
        scl_level <= lvl_scl;
        sda_level <= lvl_sda;
      end
    end
  end

endmodule

FILE: rtl/core/i2c_adc_read_master_top.sv
`timescale 1ns / 1ps
// i2c master that runs one converter read: start, address write, control byte,
// stop, then start, address read, eight data bits with no master ack, stop.
// every input beat is one bus tick: it carries start_read, control_byte and the
// sampled sda_in level, and gives exactly one output beat with the pin levels
// for that tick, busy/done, the sticky ack error and, on the done beat, the
// byte read and that byte times 500/255, truncated.
// each bus phase lasts delay_ticks beats (0 acts as 1); device_address is the
// 7-bit slave address. write both through the cfg port only while idle.
// the output beat is registered: it appears the cycle after its input is taken.
// throughput: one beat per cycle unless the output stalls; one sequencer register stage.
// a stalled output beat holds; in_stall rises only while a finished beat waits
// and the receiver stalls, and the next input beat is taken in the same cycle
// the waiting one leaves.
// reset puts the sequencer idle with the bus released, drops out_valid
// and loads delay 30 and address 72.
module i2c_adc_read_master_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       start_read,
  input  logic [7:0] control_byte,
  input  logic       sda_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       scl_out,
  output logic       sda_out,
  output logic       busy_res,
  output logic       done_res,
  output logic       ack_error,
  output logic [7:0] raw_value,
  output logic [8:0] scaled_value,
  input  logic       cfg_write,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);
  import i2car_pkg::*;

  logic [7:0] delay_ticks;
  logic [6:0] device_address;
  logic       accept;
  res_t       res;
  res_t       out_res;

  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_ticks    <= DELAY_RESET;
      device_address <= ADDR_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_DELAY_TICKS:    delay_ticks    <= cfg_data;
        CFG_DEVICE_ADDRESS: device_address <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  i2car_seq u_seq (
    .clk            (clk),
    .rst            (rst),
    .tick           (accept),
    .start_read     (start_read),
    .control_byte   (control_byte),
    .sda_in         (sda_in),
    .delay_ticks    (delay_ticks),
    .device_address (device_address),
    .res            (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_res <= res;
    end
  end

  assign scl_out      = out_res.scl;
  assign sda_out      = out_res.sda;
  assign busy_res     = out_res.busy;
  assign done_res     = out_res.done;
  assign ack_error    = out_res.ack_error;
  assign raw_value    = out_res.raw;
  assign scaled_value = out_res.scaled;

endmodule

FILE: rtl/core/i2car_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module i2car_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       busy_res,
  input logic       done_res,
  input logic [7:0] raw_value,
  input logic [8:0] scaled_value
);

  logic [16:0] data_bits;

  assign data_bits = {raw_value, scaled_value};

  // every taken input beat shows up on the output next cycle
  `ASSERT_NEXT(a_beat_out, clk, rst, in_valid && !in_stall, out_valid)

  // a stalled output beat keeps its data
  `ASSERT_NEXT(a_hold, clk, rst, out_valid && out_stall, out_valid && $stable(data_bits))

  // the finishing beat leaves the block idle
  `ASSERT_NOW(a_done_idle, clk, rst, out_valid && done_res, !busy_res)

  // data fields read zero except on the finishing beat
  `ASSERT_NOW(a_data_zero, clk, rst, out_valid && !done_res, data_bits == 17'd0)

endmodule

bind i2c_adc_read_master_top i2car_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .busy_res     (busy_res),
  .done_res     (done_res),
  .raw_value    (raw_value),
  .scaled_value (scaled_value)
);
